@@ rtl/fire_effect_frame_engine_macros.svh @@
// Assertion macros used by the checker file.
`ifndef FIRE_EFFECT_FRAME_ENGINE_MACROS_SVH
`define FIRE_EFFECT_FRAME_ENGINE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define FEFE_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define FEFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fefe_pkg.sv @@
// Types and constants of the fire effect frame engine.
package fefe_pkg;

   localparam int unsigned WIDTH_W     = 9;
   localparam int unsigned HEIGHT_W    = 8;
   localparam int unsigned WIND_W      = 3;
   localparam int unsigned MODE_W      = 3;
   localparam int unsigned DECAY_W     = 2;
   localparam int unsigned X_W         = 8;
   localparam int unsigned Y_W         = 7;
   localparam int unsigned HEAT_W      = 6;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 9;

   localparam logic [HEAT_W-1:0]   IGNITE_HEAT  = 6'd36;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd256;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 8'd128;
   localparam logic [WIND_W-1:0]   WIND_RESET   = 3'sd1;
   localparam logic [WIND_W-1:0]   WIND_MIN     = 3'b101;
   localparam logic [WIND_W-1:0]   WIND_LOW     = 3'b100;

   localparam logic [MODE_W-1:0] MODE_PROPAGATE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_IGNITE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EXTINGUISH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIND_OFFSET  = 2'd2;

   typedef enum logic [2:0] {
      OP_PROPAGATE,
      OP_IGNITE,
      OP_EXTINGUISH,
      OP_CLEAR,
      OP_READ,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      LOAD_NONE,
      LOAD_PROP,
      LOAD_READ,
      LOAD_FIXED
   } load_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PROP,
      ST_READ,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     capture;
      logic     read_en;
      logic     fill_clear;
      logic     fill_step;
      logic     fill_bottom;
      load_type load_sel;
   } cmd_type;

   typedef struct packed {
      op_type req_op;
      op_type item_op;
      logic   fill_last;
      logic   out_free;
   } status_type;

   function automatic op_type decode_mode(input logic [MODE_W-1:0] mode);
      op_type op;
      unique case (mode)
         MODE_PROPAGATE:  op = OP_PROPAGATE;
         MODE_IGNITE:     op = OP_IGNITE;
         MODE_EXTINGUISH: op = OP_EXTINGUISH;
         MODE_CLEAR:      op = OP_CLEAR;
         MODE_READ:       op = OP_READ;
         default:         op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

@@ rtl/fefe_ram.sv @@
// Generic single-port RAM with registered read.
module fefe_ram #(
   parameter int unsigned WIDTH = 6,
   parameter int unsigned DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fefe_datapath.sv @@
// Datapath: configuration, scan cursor, frame store access and result register.
module fefe_datapath import fefe_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [DECAY_W-1:0]     req_decay_roll,
   input  logic                   req_wind_roll,
   input  logic [X_W-1:0]         req_read_x,
   input  logic [Y_W-1:0]         req_read_y,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [X_W-1:0]         rsp_cell_x,
   output logic [Y_W-1:0]         rsp_cell_y,
   output logic [HEAT_W-1:0]      rsp_heat_value,
   output logic                   rsp_was_written,
   output logic                   rsp_frame_done,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
   localparam int unsigned AW    = COL_W + ROW_W;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned FW    = (AW > WIDTH_W) ? AW : WIDTH_W;
   localparam int unsigned TW    = WIDTH_W + 2;

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [WIND_W-1:0]   wind_ff, wind_in;

   logic [WIDTH_W-1:0]  col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [FW-1:0]       fill_ff, fill_in;
   op_type              op_ff, op_in;

   logic [DECAY_W-1:0]  decay_ff, decay_in;
   logic                wroll_ff, wroll_in;
   logic [X_W-1:0]      rx_ff, rx_in;
   logic [Y_W-1:0]      ry_ff, ry_in;

   logic                valid_ff, valid_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [Y_W-1:0]      y_ff, y_in;
   logic [HEAT_W-1:0]   heat_ff, heat_in;
   logic                written_ff, written_in;
   logic                done_ff, done_in;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic [HEIGHT_W-1:0] bottom_row;
   logic [WIND_W-1:0]   wind_eff;
   logic [WIDTH_W-1:0]  col_n, col_inc;
   logic [HEIGHT_W-1:0] row_n, row_inc;
   logic                wrap_col, wrap_row;
   logic [HEAT_W-1:0]   below, nv;
   logic signed [TW-1:0] target;
   logic                in_frame, rd_in_frame, bottom_op;
   logic [AW-1:0]       below_addr, read_addr, target_addr, fill_addr;
   logic [HEAT_W-1:0]   fill_val;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_addr;
   logic [HEAT_W-1:0]   ram_wdata, ram_rdata;

   fefe_ram #(
      .WIDTH (HEAT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // clamp configuration to the usable range
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < HEIGHT_W'(2)) begin
         h_eff = HEIGHT_W'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      wind_eff = (wind_ff == WIND_LOW) ? WIND_MIN : wind_ff;
   end

   assign bottom_row = h_eff - HEIGHT_W'(1);

   // restart the cursor when the frame shrank below it
   always_comb begin
      if (col_ff >= w_eff || row_ff >= bottom_row) begin
         col_n = '0;
         row_n = '0;
      end else begin
         col_n = col_ff;
         row_n = row_ff;
      end
      col_inc  = col_n + WIDTH_W'(1);
      row_inc  = row_n + HEIGHT_W'(1);
      wrap_col = col_inc >= w_eff;
      wrap_row = row_inc >= bottom_row;
   end

   always_comb begin
      below = ram_rdata;
      if (decay_ff[1]) begin
         nv = (below != '0) ? below - HEAT_W'(1) : '0;
      end else begin
         nv = below;
      end
      target = $signed({2'b00, col_n});
      if (wroll_ff) begin
         target = target + TW'($signed(wind_eff));
      end
      in_frame    = (target >= 0) && (target < $signed({2'b00, w_eff}));
      rd_in_frame = ({1'b0, rx_ff} < w_eff) && ({1'b0, ry_ff} < h_eff);
      bottom_op   = (op_ff == OP_IGNITE) || (op_ff == OP_EXTINGUISH);
   end

   assign below_addr  = {ROW_W'(row_n + HEIGHT_W'(1)), COL_W'(col_n)};
   assign read_addr   = {ROW_W'(req_read_y), COL_W'(req_read_x)};
   assign target_addr = {ROW_W'(row_n), COL_W'(target[WIDTH_W-1:0])};

   always_comb begin
      if (cmd.fill_bottom) begin
         fill_addr        = {ROW_W'(bottom_row), COL_W'(fill_ff[WIDTH_W-1:0])};
         status.fill_last = fill_ff[WIDTH_W-1:0] == (w_eff - WIDTH_W'(1));
         fill_val         = (op_ff == OP_IGNITE) ? IGNITE_HEAT : '0;
      end else begin
         fill_addr        = fill_ff[AW-1:0];
         status.fill_last = &fill_ff[AW-1:0];
         fill_val         = '0;
      end
      status.req_op   = decode_mode(req_mode);
      status.item_op  = op_ff;
      status.out_free = !valid_ff || !rsp_stall;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = below_addr;
      ram_wdata = nv;
      priority if (cmd.fill_step) begin
         ram_we    = 1'b1;
         ram_addr  = fill_addr;
         ram_wdata = fill_val;
      end else if (cmd.load_sel == LOAD_PROP) begin
         ram_we    = in_frame;
         ram_addr  = target_addr;
      end else if (cmd.read_en) begin
         ram_re    = 1'b1;
         ram_addr  = (status.req_op == OP_READ) ? read_addr : below_addr;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      wind_in   = wind_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data[HEIGHT_W-1:0];
            CSR_WIND_OFFSET:  wind_in   = csr_data[WIND_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      fill_in  = fill_ff;
      op_in    = op_ff;
      decay_in = decay_ff;
      wroll_in = wroll_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      if (cmd.capture) begin
         op_in    = status.req_op;
         decay_in = req_decay_roll;
         wroll_in = req_wind_roll;
         rx_in    = req_read_x;
         ry_in    = req_read_y;
      end
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (cmd.fill_step) begin
         fill_in = fill_ff + FW'(1);
      end
      if (cmd.load_sel == LOAD_PROP) begin
         col_in = wrap_col ? '0 : col_inc;
         row_in = wrap_col ? (wrap_row ? '0 : row_inc) : row_n;
      end
   end

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      heat_in    = heat_ff;
      written_in = written_ff;
      done_in    = done_ff;
      valid_in   = valid_ff && rsp_stall;
      unique case (cmd.load_sel)
         LOAD_PROP: begin
            valid_in   = 1'b1;
            x_in       = in_frame ? target[X_W-1:0] : col_n[X_W-1:0];
            y_in       = row_n[Y_W-1:0];
            heat_in    = nv;
            written_in = in_frame;
            done_in    = wrap_col && wrap_row;
         end
         LOAD_READ: begin
            valid_in   = 1'b1;
            x_in       = rx_ff;
            y_in       = ry_ff;
            heat_in    = rd_in_frame ? ram_rdata : '0;
            written_in = 1'b0;
            done_in    = 1'b0;
         end
         LOAD_FIXED: begin
            valid_in   = 1'b1;
            x_in       = '0;
            y_in       = bottom_op ? bottom_row[Y_W-1:0] : '0;
            heat_in    = (op_ff == OP_IGNITE) ? IGNITE_HEAT : '0;
            written_in = 1'b0;
            done_in    = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         wind_ff   <= WIND_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         fill_ff   <= '0;
         op_ff     <= OP_NONE;
         valid_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         wind_ff   <= wind_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         fill_ff   <= fill_in;
         op_ff     <= op_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      decay_ff   <= decay_in;
      wroll_ff   <= wroll_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      heat_ff    <= heat_in;
      written_ff <= written_in;
      done_ff    <= done_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_cell_x      = x_ff;
   assign rsp_cell_y      = y_ff;
   assign rsp_heat_value  = heat_ff;
   assign rsp_was_written = written_ff;
   assign rsp_frame_done  = done_ff;

endmodule

@@ rtl/fefe_ctrl.sv @@
// Controller state machine sequencing item acceptance, store sweeps and result loads.
module fefe_ctrl import fefe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.capture     = 1'b0;
      cmd.read_en     = 1'b0;
      cmd.fill_clear  = 1'b0;
      cmd.fill_step   = 1'b0;
      cmd.fill_bottom = 1'b0;
      cmd.load_sel    = LOAD_NONE;
      req_stall       = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.read_en = 1'b1;
            if (req_valid) begin
               cmd.capture    = 1'b1;
               cmd.fill_clear = 1'b1;
               unique case (status.req_op)
                  OP_PROPAGATE:  state_in = ST_PROP;
                  OP_READ:       state_in = ST_READ;
                  OP_IGNITE,
                  OP_EXTINGUISH,
                  OP_CLEAR:      state_in = ST_FILL;
                  default:       state_in = ST_DONE;
               endcase
            end
         end
         ST_PROP: begin
            if (status.out_free) begin
               cmd.load_sel = LOAD_PROP;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (status.out_free) begin
               cmd.load_sel = LOAD_READ;
               state_in     = ST_IDLE;
            end
         end
         ST_FILL: begin
            cmd.fill_step   = 1'b1;
            cmd.fill_bottom = (status.item_op == OP_IGNITE) ||
                              (status.item_op == OP_EXTINGUISH);
            if (status.fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_sel = LOAD_FIXED;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

endmodule

@@ rtl/fire_effect_frame_engine.sv @@
// Top level of the fire effect frame engine.
//
// Request words carry a mode, a decay roll, a wind roll and read coordinates;
// each accepted word (req_valid high, req_stall low) yields exactly one response
// word on the rsp_ channel. The csr_ port writes frame width, height and wind.
// Propagate and read words make one single-port frame store access to fetch
// the cell, then the write (propagate only) and the result load, which waits
// while rsp_stall holds the output register. req_stall stays high until the
// word is done, so a new word is taken only once the last one is through.
// Ignite and extinguish sweep the bottom row, one cell per cycle; clear
// sweeps the whole store, 2^clog2(MAX_HEIGHT) * 2^clog2(MAX_WIDTH) cells.
// After reset the store is zeroed by the same sweep, with req_stall high;
// configuration writes are taken meanwhile.
// The response sits in an output register; a request may be accepted while it
// waits, and the next result loads once rsp_stall drops.
module fire_effect_frame_engine import fefe_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [DECAY_W-1:0]     req_decay_roll,
   input  logic                   req_wind_roll,
   input  logic [X_W-1:0]         req_read_x,
   input  logic [Y_W-1:0]         req_read_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [X_W-1:0]         rsp_cell_x,
   output logic [Y_W-1:0]         rsp_cell_y,
   output logic [HEAT_W-1:0]      rsp_heat_value,
   output logic                   rsp_was_written,
   output logic                   rsp_frame_done,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   fefe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fefe_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_decay_roll  (req_decay_roll),
      .req_wind_roll   (req_wind_roll),
      .req_read_x      (req_read_x),
      .req_read_y      (req_read_y),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_heat_value  (rsp_heat_value),
      .rsp_was_written (rsp_was_written),
      .rsp_frame_done  (rsp_frame_done),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

@@ rtl/fefe_checker.sv @@
// Port-level checker of the fire effect frame engine and its bind.
`include "fire_effect_frame_engine_macros.svh"

module fefe_checker import fefe_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [MODE_W-1:0]      req_mode,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [X_W-1:0]         rsp_cell_x,
   input logic [Y_W-1:0]         rsp_cell_y,
   input logic [HEAT_W-1:0]      rsp_heat_value,
   input logic                   rsp_was_written,
   input logic                   rsp_frame_done
);

   `FEFE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_cell_x) && $stable(rsp_cell_y) && $stable(rsp_heat_value) && $stable(rsp_was_written) && $stable(rsp_frame_done), "stalled response word changed")
   `FEFE_ASSERT(a_init_sweep, $past(reset), req_stall, "request taken during store clearing")
   `FEFE_ASSERT_NEXT(a_prop_busy, req_valid && !req_stall && req_mode == MODE_PROPAGATE, req_stall, "propagate word did not hold the request side")
   `FEFE_ASSERT(a_heat_range, rsp_valid, rsp_heat_value <= IGNITE_HEAT, "heat above ignition level")

endmodule

bind fire_effect_frame_engine fefe_checker u_checker (.*);

@@ dv/fire_effect_frame_engine_test.sv @@
// Self-checking testbench of the fire effect frame engine, with a heat frame scoreboard.
module fire_effect_frame_engine_test import fefe_pkg::*; ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_COLS    = 256;
   localparam int FRAME_ROWS    = 128;
   localparam int PHASES        = 15;
   localparam int PHASE_WORDS   = 128;
   localparam int SETTLE_CYCLES = FRAME_COLS + 16;
   localparam int HOLD_CYCLES   = 600;
   localparam int HOLD_PHASE    = 5;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [DECAY_W-1:0] decay;
      logic               wind;
      logic [X_W-1:0]     read_x;
      logic [Y_W-1:0]     read_y;
   } request_type;

   typedef struct packed {
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [HEAT_W-1:0] heat;
      logic              written;
      logic              done;
   } cell_word_type;

   typedef enum {PACE_STEADY, PACE_RANDOM, PACE_SPARSE} pace_type;

   class heat_frame_tracker;
      logic [HEAT_W-1:0]   heat_cells [FRAME_COLS*FRAME_ROWS];
      int                  scan_col;
      int                  scan_row;
      logic [WIDTH_W-1:0]  width_reg;
      logic [HEIGHT_W-1:0] height_reg;
      logic [WIND_W-1:0]   wind_reg;
      cell_word_type       expected_cells [$];
      int unsigned         mismatches;

      function new();
         clear_cells();
         scan_col   = 0;
         scan_row   = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         wind_reg   = WIND_RESET;
         mismatches = 0;
      endfunction

      function void clear_cells();
         foreach (heat_cells[i]) heat_cells[i] = '0;
      endfunction

      function int used_cols();
         int w;
         w = int'(width_reg);
         if (w < 1) w = 1;
         if (w > FRAME_COLS) w = FRAME_COLS;
         return w;
      endfunction

      function int used_rows();
         int h;
         h = int'(height_reg);
         if (h < 2) h = 2;
         if (h > FRAME_ROWS) h = FRAME_ROWS;
         return h;
      endfunction

      function int wind_shift();
         int s;
         s = int'($signed(wind_reg));
         if (s < -3) s = -3;
         return s;
      endfunction

      function void note_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         unique case (index)
            CSR_FRAME_WIDTH: width_reg = data[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: height_reg = data[HEIGHT_W-1:0];
            CSR_WIND_OFFSET: wind_reg = data[WIND_W-1:0];
            default: ;
         endcase
      endfunction

      function void absorb_word(request_type rq);
         cell_word_type     c;
         int                w;
         int                h;
         int                target;
         logic [HEAT_W-1:0] below;
         logic [HEAT_W-1:0] fresh;
         c = '0;
         w = used_cols();
         h = used_rows();
         unique case (rq.mode)
            MODE_PROPAGATE: begin
               if (scan_col >= w || scan_row >= h - 1) begin
                  scan_col = 0;
                  scan_row = 0;
               end
               below = heat_cells[scan_col + FRAME_COLS * (scan_row + 1)];
               fresh = (rq.decay > DECAY_W'(1) && below != '0) ? below - HEAT_W'(1) : below;
               target = scan_col;
               if (rq.wind && wind_shift() != 0) target += wind_shift();
               c.heat = fresh;
               c.y = Y_W'(scan_row);
               if (target >= 0 && target < w) begin
                  heat_cells[target + FRAME_COLS * scan_row] = fresh;
                  c.x = X_W'(target);
                  c.written = 1'b1;
               end else begin
                  c.x = X_W'(scan_col);
               end
               scan_col++;
               if (scan_col >= w) begin
                  scan_col = 0;
                  scan_row++;
                  if (scan_row >= h - 1) begin
                     scan_row = 0;
                     c.done = 1'b1;
                  end
               end
            end
            MODE_IGNITE, MODE_EXTINGUISH: begin
               fresh = (rq.mode == MODE_IGNITE) ? IGNITE_HEAT : '0;
               for (int x = 0; x < w; x++) heat_cells[x + FRAME_COLS * (h - 1)] = fresh;
               c.y = Y_W'(h - 1);
               c.heat = fresh;
            end
            MODE_CLEAR: clear_cells();
            MODE_READ: begin
               c.x = rq.read_x;
               c.y = rq.read_y;
               if (int'(rq.read_x) < w && int'(rq.read_y) < h)
                  c.heat = heat_cells[int'(rq.read_x) + FRAME_COLS * int'(rq.read_y)];
            end
            default: ;
         endcase
         expected_cells.push_back(c);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void compare_cell(cell_word_type got);
         cell_word_type want;
         if (expected_cells.size() == 0) begin
            $display("%0t ns: response word expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_cells.pop_front();
         check_field("cell_x", want.x, got.x);
         check_field("cell_y", 8'(want.y), 8'(got.y));
         check_field("heat_value", 8'(want.heat), 8'(got.heat));
         check_field("was_written", 8'(want.written), 8'(got.written));
         check_field("frame_done", 8'(want.done), 8'(got.done));
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode = '0;
   logic [DECAY_W-1:0]     req_decay_roll = '0;
   logic                   req_wind_roll = 1'b0;
   logic [X_W-1:0]         req_read_x = '0;
   logic [Y_W-1:0]         req_read_y = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [X_W-1:0]         rsp_cell_x;
   logic [Y_W-1:0]         rsp_cell_y;
   logic [HEAT_W-1:0]      rsp_heat_value;
   logic                   rsp_was_written;
   logic                   rsp_frame_done;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   heat_frame_tracker tracker = new();
   pace_type          sender_pace = PACE_STEADY;
   pace_type          receiver_pace = PACE_STEADY;
   int unsigned       clears_left = 4;
   int unsigned       stall_left = 0;
   logic              hold_request = 1'b0;
   logic              hold_output = 1'b0;

   fire_effect_frame_engine #(
      .MAX_WIDTH(FRAME_COLS),
      .MAX_HEIGHT(FRAME_ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_decay_roll(req_decay_roll),
      .req_wind_roll(req_wind_roll),
      .req_read_x(req_read_x),
      .req_read_y(req_read_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_x(rsp_cell_x),
      .rsp_cell_y(rsp_cell_y),
      .rsp_heat_value(rsp_heat_value),
      .rsp_was_written(rsp_was_written),
      .rsp_frame_done(rsp_frame_done),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic int draw_pause(pace_type pace);
      unique case (pace)
         PACE_STEADY: return 0;
         PACE_RANDOM: return int'($urandom_range(0, 16));
         default: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      endcase
   endfunction

   function automatic request_type make_word(logic [MODE_W-1:0] mode, logic [DECAY_W-1:0] decay,
                                             logic wind, logic [X_W-1:0] x, logic [Y_W-1:0] y);
      request_type rq;
      rq.mode   = mode;
      rq.decay  = decay;
      rq.wind   = wind;
      rq.read_x = x;
      rq.read_y = y;
      return rq;
   endfunction

   function automatic request_type random_word();
      request_type rq;
      int          pick;
      rq.decay  = DECAY_W'($urandom_range(0, 3));
      rq.wind   = 1'($urandom_range(0, 1));
      rq.read_x = X_W'($urandom);
      rq.read_y = Y_W'($urandom);
      pick = int'($urandom_range(0, 99));
      if (pick < 70) begin
         rq.mode = MODE_PROPAGATE;
      end else if (pick < 78) begin
         rq.mode = MODE_IGNITE;
      end else if (pick < 81) begin
         rq.mode = MODE_EXTINGUISH;
      end else if (pick < 93) begin
         rq.mode = MODE_READ;
         if ($urandom_range(0, 1) != 0) begin
            rq.read_x = X_W'($urandom_range(0, tracker.used_cols() - 1));
            rq.read_y = Y_W'($urandom_range(0, tracker.used_rows() - 1));
         end
      end else if (pick < 97) begin
         rq.mode = MODE_READ + MODE_W'($urandom_range(1, 3));
      end else if (clears_left != 0) begin
         rq.mode = MODE_CLEAR;
         clears_left--;
      end else begin
         rq.mode = MODE_PROPAGATE;
      end
      return rq;
   endfunction

   task automatic drive_word(input request_type rq);
      int pause;
      pause = draw_pause(sender_pace);
      if (pause != 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_mode       <= rq.mode;
      req_decay_roll <= rq.decay;
      req_wind_roll  <= rq.wind;
      req_read_x     <= rq.read_x;
      req_read_y     <= rq.read_y;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.absorb_word(rq);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_index <= index;
      csr_data  <= data;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
      tracker.note_register(index, data);
      @(posedge clock);
   endtask

   task automatic configure(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h,
                            input logic [WIND_W-1:0] wind);
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_register(CSR_WIND_OFFSET, CSR_DATA_W'(wind));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            tracker.compare_cell({rsp_cell_x, rsp_cell_y, rsp_heat_value,
                                  rsp_was_written, rsp_frame_done});
            stall_left = draw_pause(receiver_pace);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0) || hold_output;
      end
   end

   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_output <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_output <= 1'b0;
   end

   initial begin
      #8_000_000;
      $display("fire_effect_frame_engine: mismatch");
      $finish;
   end

   initial begin
      logic [WIDTH_W-1:0]  w;
      logic [HEIGHT_W-1:0] h;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'hFF, 7'h7F));
      drive_word(make_word(MODE_IGNITE, 2'd0, 1'b0, 8'd0, 7'd0));
      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'hFF, 7'h7F));
      drive_word(make_word(MODE_PROPAGATE, 2'd3, 1'b1, 8'd0, 7'd0));
      for (int k = 1; k <= 3; k++)
         drive_word(make_word(MODE_READ + MODE_W'(k), 2'd3, 1'b1, 8'hFF, 7'h7F));
      drain();

      configure(9'd4, 8'd3, 3'd1);
      drive_word(make_word(MODE_IGNITE, 2'd0, 1'b0, 8'd0, 7'd0));
      for (int i = 0; i < 8; i++)
         drive_word(make_word(MODE_PROPAGATE, DECAY_W'(i % 4), 1'(i % 2), 8'd0, 7'd0));
      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'd0, 7'd1));
      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'd3, 7'd0));
      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'd4, 7'd0));
      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'd0, 7'd3));
      drive_word(make_word(MODE_EXTINGUISH, 2'd0, 1'b0, 8'd0, 7'd0));
      drive_word(make_word(MODE_PROPAGATE, 2'd2, 1'b0, 8'd0, 7'd0));
      drive_word(make_word(MODE_CLEAR, 2'd0, 1'b0, 8'd0, 7'd0));
      drive_word(make_word(MODE_READ, 2'd0, 1'b0, 8'd1, 7'd1));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         unique case (p)
            0: configure(9'd511, 8'd255, WIND_LOW);
            1: configure(9'd0, 8'd0, 3'd0);
            2: configure(9'd1, 8'd2, 3'd3);
            3: configure(9'd256, 8'd128, WIND_MIN);
            default: begin
               w = ($urandom_range(0, 3) == 0) ? WIDTH_W'($urandom_range(9, 24))
                                               : WIDTH_W'($urandom_range(1, 8));
               h = ($urandom_range(0, 3) == 0) ? HEIGHT_W'($urandom_range(6, 12))
                                               : HEIGHT_W'($urandom_range(2, 5));
               configure(w, h, WIND_W'($urandom_range(0, 7)));
            end
         endcase
         sender_pace   = pace_type'($urandom_range(0, 2));
         receiver_pace = pace_type'($urandom_range(0, 2));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == HOLD_PHASE && n == 20) hold_request = 1'b1;
            drive_word(random_word());
         end
         drain();
      end

      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("fire_effect_frame_engine: match");
      end else begin
         $display("fire_effect_frame_engine: mismatch");
      end
      $finish;
   end

endmodule
